// File: hdl/ple_pkg.sv
// shared constants, codes and control types for the positional list engine
// used by ple_cell and positional_list_engine_unit; depends on nothing
package ple_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 10;
  localparam int VAL_W    = 64;
  localparam int OP_W     = 3;
  localparam int ST_W     = 2;
  localparam int CMP_W    = (POS_W > LEN_W) ? POS_W : LEN_W;

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;
  localparam logic [OP_W-1:0] OP_DUMP   = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd6;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_WRITE
  } cell_op_t;

  typedef struct packed {
    cell_op_t               op;
    logic [IDX_W-1:0]       pos;
    logic                   rd_load;
    logic                   rd_shift;
  } cell_ctl_t;

endpackage

// File: hdl/ple_cell.sv
// one storage cell of the list: element register plus readout register
// depends on ple_pkg for widths and the broadcast control struct
module ple_cell (
  input  logic                              clk,
  input  logic [ple_pkg::IDX_W-1:0]         cell_idx,
  input  ple_pkg::cell_ctl_t                ctl,
  input  logic [ple_pkg::VAL_W-1:0]         wr_value,
  input  logic [ple_pkg::VAL_W-1:0]         left_elem,
  input  logic [ple_pkg::VAL_W-1:0]         right_elem,
  input  logic [ple_pkg::VAL_W-1:0]         right_rd,
  output logic [ple_pkg::VAL_W-1:0]         elem,
  output logic [ple_pkg::VAL_W-1:0]         rd
);

  logic [ple_pkg::VAL_W-1:0] elem_r, elem_nxt;
  logic [ple_pkg::VAL_W-1:0] rd_r, rd_nxt;
  logic                      at_pos, past_pos;

  assign at_pos   = (cell_idx == ctl.pos);
  assign past_pos = (cell_idx > ctl.pos);

  always_comb begin
    elem_nxt = elem_r;
    case (ctl.op)
      ple_pkg::CELL_INSERT: begin
        if (past_pos) elem_nxt = left_elem;
        else if (at_pos) elem_nxt = wr_value;
      end
      ple_pkg::CELL_DELETE: begin
        if (past_pos || at_pos) elem_nxt = right_elem;
      end
      ple_pkg::CELL_WRITE: begin
        if (at_pos) elem_nxt = wr_value;
      end
      default: elem_nxt = elem_r;
    endcase
  end

  // readout chain snapshots the elements, then moves toward cell zero
  always_comb begin
    rd_nxt = rd_r;
    if (ctl.rd_load) rd_nxt = elem_r;
    else if (ctl.rd_shift) rd_nxt = right_rd;
  end

  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
    rd_r   <= rd_nxt;
  end

  assign elem = elem_r;
  assign rd   = rd_r;

endmodule

// File: hdl/positional_list_engine_unit.sv
// top level of the positional list engine: command decode, length count,
// readout sequencing and result register over a chain of ple_cell
// depends on ple_pkg and ple_cell
//
// usage: one command beat enters on in_* (valid/ready); results leave on
// out_* (valid/ready), each with the list length after the command.
// append, insert, delete and overwrite update the cells on acceptance, clear
// zeroes the length; each gives one result beat on the next cycle, so they
// sustain one command per cycle while the receiver keeps up.
// read at position p snapshots the cells into the readout chain and shifts
// it toward cell zero until element p sits there; that gives the result beat.
// dump of n elements loads the readout chain, then streams one beat per cycle
// unless stalled; last marks the final beat; an empty dump gives a range beat.
// the next command is taken once the previous command's last beat is in the
// result register and that register is free or being drained in the same
// cycle. a stalled receiver holds the result and pauses a dump in place.
// reset empties the list (length zero); cell contents are not cleared.
module positional_list_engine_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ple_pkg::OP_W-1:0]          in_opcode,
  input  logic [ple_pkg::POS_W-1:0]         in_position,
  input  logic signed [ple_pkg::VAL_W-1:0]  in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ple_pkg::ST_W-1:0]          out_status,
  output logic signed [ple_pkg::VAL_W-1:0]  out_read_value,
  output logic [ple_pkg::IDX_W-1:0]         out_element_index,
  output logic [ple_pkg::LEN_W-1:0]         out_list_length,
  output logic                              out_last
);

  typedef enum logic {
    S_IDLE,
    S_STREAM
  } state_t;

  state_t                       state_r, state_nxt;
  logic [ple_pkg::LEN_W-1:0]    count_r, count_nxt;
  logic [ple_pkg::IDX_W-1:0]    k_r, k_nxt;
  logic [ple_pkg::IDX_W-1:0]    tgt_r, tgt_nxt;
  logic                         dump_r, dump_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [ple_pkg::ST_W-1:0]     out_status_r;
  logic [ple_pkg::VAL_W-1:0]    out_value_r;
  logic [ple_pkg::IDX_W-1:0]    out_idx_r;
  logic                         out_last_r;

  ple_pkg::cell_ctl_t           ctl;
  logic                         accept, out_free, emit;
  logic [ple_pkg::ST_W-1:0]     e_status;
  logic [ple_pkg::VAL_W-1:0]    e_value;
  logic [ple_pkg::IDX_W-1:0]    e_idx;
  logic                         e_last;
  logic [ple_pkg::CMP_W-1:0]    pos_ext, cnt_ext, n_ext;
  logic                         full, out_of_range;

  logic [ple_pkg::VAL_W-1:0] elem [ple_pkg::CAPACITY];
  logic [ple_pkg::VAL_W-1:0] rd   [ple_pkg::CAPACITY];

  genvar gi;
  generate
    for (gi = 0; gi < ple_pkg::CAPACITY; gi++) begin : g_cell
      logic [ple_pkg::VAL_W-1:0] left_e, right_e, right_r;
      if (gi == 0) begin : g_first
        assign left_e = '0;
      end else begin : g_mid_l
        assign left_e = elem[gi-1];
      end
      if (gi == ple_pkg::CAPACITY - 1) begin : g_last
        assign right_e = elem[gi];
        assign right_r = '0;
      end else begin : g_mid_r
        assign right_e = elem[gi+1];
        assign right_r = rd[gi+1];
      end
      ple_cell u_cell (
        .clk        (clk),
        .cell_idx   (ple_pkg::IDX_W'(gi)),
        .ctl        (ctl),
        .wr_value   (in_value),
        .left_elem  (left_e),
        .right_elem (right_e),
        .right_rd   (right_r),
        .elem       (elem[gi]),
        .rd         (rd[gi])
      );
    end
  endgenerate

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  assign pos_ext      = ple_pkg::CMP_W'(in_position);
  assign cnt_ext      = ple_pkg::CMP_W'(count_r);
  assign full         = (cnt_ext >= ple_pkg::CMP_W'(ple_pkg::CAPACITY));
  assign out_of_range = (pos_ext >= cnt_ext);
  assign n_ext        = (pos_ext < cnt_ext) ? pos_ext : cnt_ext;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    k_nxt        = k_r;
    tgt_nxt      = tgt_r;
    dump_nxt     = dump_r;
    ctl.op       = ple_pkg::CELL_HOLD;
    ctl.pos      = in_position[ple_pkg::IDX_W-1:0];
    ctl.rd_load  = 1'b0;
    ctl.rd_shift = 1'b0;
    emit         = 1'b0;
    e_status     = ple_pkg::ST_OK;
    e_value      = '0;
    e_idx        = '0;
    e_last       = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_opcode) inside
            ple_pkg::OP_APPEND, ple_pkg::OP_INSERT: begin
              emit = 1'b1;
              if (full) begin
                e_status = ple_pkg::ST_FULL;
              end else begin
                ctl.op = ple_pkg::CELL_INSERT;
                // append, or insert past the end, lands at the tail
                if (in_opcode == ple_pkg::OP_APPEND || pos_ext > cnt_ext)
                  ctl.pos = count_r[ple_pkg::IDX_W-1:0];
                count_nxt = count_r + 1'b1;
              end
            end
            ple_pkg::OP_DELETE: begin
              emit = 1'b1;
              if (out_of_range) begin
                e_status = ple_pkg::ST_RANGE;
              end else begin
                ctl.op    = ple_pkg::CELL_DELETE;
                count_nxt = count_r - 1'b1;
              end
            end
            ple_pkg::OP_WRITE: begin
              emit = 1'b1;
              if (out_of_range) e_status = ple_pkg::ST_RANGE;
              else ctl.op = ple_pkg::CELL_WRITE;
            end
            ple_pkg::OP_READ: begin
              if (out_of_range) begin
                emit     = 1'b1;
                e_status = ple_pkg::ST_RANGE;
              end else begin
                ctl.rd_load = 1'b1;
                k_nxt       = '0;
                tgt_nxt     = in_position[ple_pkg::IDX_W-1:0];
                dump_nxt    = 1'b0;
                state_nxt   = S_STREAM;
              end
            end
            ple_pkg::OP_DUMP: begin
              if (n_ext == '0) begin
                emit     = 1'b1;
                e_status = ple_pkg::ST_RANGE;
              end else begin
                ctl.rd_load = 1'b1;
                k_nxt       = '0;
                tgt_nxt     = ple_pkg::IDX_W'(n_ext - 1'b1);
                dump_nxt    = 1'b1;
                state_nxt   = S_STREAM;
              end
            end
            ple_pkg::OP_CLEAR: begin
              emit      = 1'b1;
              count_nxt = '0;
            end
            default: begin
              emit     = 1'b1;
              e_status = ple_pkg::ST_RANGE;
            end
          endcase
        end
      end
      S_STREAM: begin
        // cell zero of the readout chain holds element k_r
        if (dump_r || k_r == tgt_r) begin
          if (out_free) begin
            emit         = 1'b1;
            e_value      = rd[0];
            e_idx        = dump_r ? k_r : '0;
            e_last       = (k_r == tgt_r);
            ctl.rd_shift = 1'b1;
            k_nxt        = k_r + 1'b1;
            if (k_r == tgt_r) state_nxt = S_IDLE;
          end
        end else begin
          ctl.rd_shift = 1'b1;
          k_nxt        = k_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = emit || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      tgt_r       <= '0;
      dump_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      tgt_r       <= tgt_nxt;
      dump_r      <= dump_nxt;
    end
    if (emit) begin
      out_status_r <= e_status;
      out_value_r  <= e_value;
      out_idx_r    <= e_idx;
      out_last_r   <= e_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_read_value    = out_value_r;
  assign out_element_index = out_idx_r;
  assign out_list_length   = count_r;
  assign out_last          = out_last_r;

endmodule
